>>> rtl/s5hp_pkg.sv
// ----------------------------------------------------------------------------
// s5hp_pkg
// Shared types and constants for the SOCKS5 header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package s5hp_pkg;

  // Register port geometry
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Protocol constants
  localparam logic [7:0] SOCKS_VERSION = 8'd5;
  localparam logic [7:0] ATYP_IPV4     = 8'd1;
  localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
  localparam logic [7:0] ATYP_IPV6     = 8'd4;
  localparam logic [7:0] IPV4_LEN      = 8'd4;
  localparam logic [7:0] IPV6_LEN      = 8'd16;

  // Parse phase, one-hot
  typedef enum logic [9:0] {
    PH_FIRST  = 10'b00_0000_0001,
    PH_SECOND = 10'b00_0000_0010,
    PH_THIRD  = 10'b00_0000_0100,
    PH_ATYP   = 10'b00_0000_1000,
    PH_DLEN   = 10'b00_0001_0000,
    PH_ADDR   = 10'b00_0010_0000,
    PH_PORTH  = 10'b00_0100_0000,
    PH_PORTL  = 10'b00_1000_0000,
    PH_TAIL   = 10'b01_0000_0000,
    PH_ERROR  = 10'b10_0000_0000
  } phase_e;

  // Byte roles
  typedef enum logic [3:0] {
    ROLE_RESERVED = 4'd0,
    ROLE_FRAGMENT = 4'd1,
    ROLE_VERSION  = 4'd2,
    ROLE_COMMAND  = 4'd3,
    ROLE_ATYP     = 4'd4,
    ROLE_DLEN     = 4'd5,
    ROLE_ADDRESS  = 4'd6,
    ROLE_PORT_HI  = 4'd7,
    ROLE_PORT_LO  = 4'd8,
    ROLE_PAYLOAD  = 4'd9,
    ROLE_IGNORED  = 4'd10
  } role_e;

  // Address kinds
  typedef enum logic [1:0] {
    KIND_IPV4    = 2'd0,
    KIND_DOMAIN  = 2'd1,
    KIND_IPV6    = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;

  // Message status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_TRUNCATED   = 2'd1,
    ST_BAD_ATYP    = 2'd2,
    ST_BAD_VERSION = 2'd3
  } status_e;

  // Register indexes
  localparam logic [PADDR_W-3:0] REG_HEADER_MODE = '0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] role;
    logic [1:0] address_kind;
    logic [7:0] byte_index;
    logic       last;
    logic [1:0] status;
  } out_t;

endpackage

`default_nettype wire

>>> rtl/socks5_header_parser.sv
// ----------------------------------------------------------------------------
// socks5_header_parser
// Tags each byte of a SOCKS5 UDP or TCP header with its role and reports
// the message status on the final byte.
// ----------------------------------------------------------------------------
// The result of each accepted word is registered in the output stage.
// Throughput: one word per cycle while the skid entry is empty; the phase machine
// and address counters update in the accept cycle, so words stream back to back.
// A two-entry output stage (result register plus skid) decouples the sides.
// Reset: rst_ni clears phase, counters, error, header_mode and valid flags.
`default_nettype none

module socks5_header_parser (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // Input words
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  s5hp_pkg::in_t               in_data_i,
  // Result words
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output s5hp_pkg::out_t                    out_data_o,
  // Register port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [s5hp_pkg::PADDR_W-1:0]      paddr,
  input  wire  [s5hp_pkg::PDATA_W-1:0]      pwdata,
  output logic [s5hp_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  // Configuration
  logic header_mode_q;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[s5hp_pkg::PADDR_W-1:2] == s5hp_pkg::REG_HEADER_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && reg_sel) begin
      header_mode_q <= pwdata[0];
    end
  end

  // Read back the register
  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata[0] = header_mode_q;
    end
  end

  // Message state
  s5hp_pkg::phase_e phase_q, phase_d;
  logic [1:0]       kind_q, kind_d;
  logic [7:0]       left_q, left_d;
  logic [7:0]       count_q, count_d;
  logic [1:0]       err_q, err_d;

  // Output stage
  logic           out_valid_q, skid_valid_q;
  s5hp_pkg::out_t out_q, skid_q;
  s5hp_pkg::out_t res;

  logic accept, pop, tcp;
  logic [3:0] role;
  logic [7:0] idx;
  logic [1:0] status;
  logic [7:0] b;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign pop        = out_valid_q && out_ready_i;
  assign tcp        = header_mode_q;
  assign b          = in_data_i.data_byte;

  // Decode one word against the current phase
  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    left_d  = left_q;
    count_d = count_q;
    err_d   = err_q;
    role    = s5hp_pkg::ROLE_IGNORED;
    idx     = 8'd0;
    status  = s5hp_pkg::ST_OK;

    unique case (phase_q)
      s5hp_pkg::PH_FIRST: begin
        if (tcp) begin
          role = s5hp_pkg::ROLE_VERSION;
          if (b != s5hp_pkg::SOCKS_VERSION) begin
            err_d   = s5hp_pkg::ST_BAD_VERSION;
            phase_d = s5hp_pkg::PH_ERROR;
          end else begin
            phase_d = s5hp_pkg::PH_SECOND;
          end
        end else begin
          role    = s5hp_pkg::ROLE_RESERVED;
          phase_d = s5hp_pkg::PH_SECOND;
        end
      end
      s5hp_pkg::PH_SECOND: begin
        role    = tcp ? s5hp_pkg::ROLE_COMMAND : s5hp_pkg::ROLE_RESERVED;
        phase_d = s5hp_pkg::PH_THIRD;
      end
      s5hp_pkg::PH_THIRD: begin
        role    = tcp ? s5hp_pkg::ROLE_RESERVED : s5hp_pkg::ROLE_FRAGMENT;
        phase_d = s5hp_pkg::PH_ATYP;
      end
      s5hp_pkg::PH_ATYP: begin
        role    = s5hp_pkg::ROLE_ATYP;
        count_d = 8'd0;
        if (b == s5hp_pkg::ATYP_IPV4) begin
          kind_d  = s5hp_pkg::KIND_IPV4;
          left_d  = s5hp_pkg::IPV4_LEN;
          phase_d = s5hp_pkg::PH_ADDR;
        end else if (b == s5hp_pkg::ATYP_IPV6) begin
          kind_d  = s5hp_pkg::KIND_IPV6;
          left_d  = s5hp_pkg::IPV6_LEN;
          phase_d = s5hp_pkg::PH_ADDR;
        end else if (b == s5hp_pkg::ATYP_DOMAIN) begin
          kind_d  = s5hp_pkg::KIND_DOMAIN;
          phase_d = s5hp_pkg::PH_DLEN;
        end else begin
          kind_d  = s5hp_pkg::KIND_UNKNOWN;
          err_d   = s5hp_pkg::ST_BAD_ATYP;
          phase_d = s5hp_pkg::PH_ERROR;
        end
      end
      s5hp_pkg::PH_DLEN: begin
        role    = s5hp_pkg::ROLE_DLEN;
        left_d  = b;
        count_d = 8'd0;
        phase_d = (b != 8'd0) ? s5hp_pkg::PH_ADDR : s5hp_pkg::PH_PORTH;
      end
      s5hp_pkg::PH_ADDR: begin
        role    = s5hp_pkg::ROLE_ADDRESS;
        idx     = count_q;
        count_d = count_q + 8'd1;
        if (left_q <= 8'd1) begin
          left_d  = 8'd0;
          phase_d = s5hp_pkg::PH_PORTH;
        end else begin
          left_d  = left_q - 8'd1;
        end
      end
      s5hp_pkg::PH_PORTH: begin
        role    = s5hp_pkg::ROLE_PORT_HI;
        phase_d = s5hp_pkg::PH_PORTL;
      end
      s5hp_pkg::PH_PORTL: begin
        role    = s5hp_pkg::ROLE_PORT_LO;
        phase_d = s5hp_pkg::PH_TAIL;
      end
      s5hp_pkg::PH_TAIL: begin
        role = tcp ? s5hp_pkg::ROLE_IGNORED : s5hp_pkg::ROLE_PAYLOAD;
      end
      default: begin
        role    = s5hp_pkg::ROLE_IGNORED;
        phase_d = s5hp_pkg::PH_ERROR;
      end
    endcase

    // Assemble the result before the end-of-message clear
    res.out_byte     = b;
    res.role         = role;
    res.address_kind = kind_d;
    res.byte_index   = idx;
    res.last         = in_data_i.end_of_message;

    // Report status and restart on the final word
    if (in_data_i.end_of_message) begin
      if (err_d != s5hp_pkg::ST_OK) begin
        status = err_d;
      end else if (phase_d == s5hp_pkg::PH_TAIL) begin
        status = s5hp_pkg::ST_OK;
      end else begin
        status = s5hp_pkg::ST_TRUNCATED;
      end
      phase_d = s5hp_pkg::PH_FIRST;
      kind_d  = s5hp_pkg::KIND_UNKNOWN;
      left_d  = 8'd0;
      count_d = 8'd0;
      err_d   = s5hp_pkg::ST_OK;
    end
    res.status = status;
  end

  // Advance message state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= s5hp_pkg::PH_FIRST;
      kind_q  <= s5hp_pkg::KIND_UNKNOWN;
      left_q  <= 8'd0;
      count_q <= 8'd0;
      err_q   <= s5hp_pkg::ST_OK;
    end else if (accept) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      left_q  <= left_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

  // Output and skid valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else if (!accept) begin
        out_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Output and skid payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      if (!out_valid_q) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
